@@ sv/csr_sparse_matrix_engine_defines.svh @@
// ----------------------------------------------------------------------------
// csr_sparse_matrix_engine_defines.svh
// Assertion macros for the checker file of the sparse matrix engine.
// ----------------------------------------------------------------------------
`ifndef CSR_SPARSE_MATRIX_ENGINE_DEFINES_SVH
`define CSR_SPARSE_MATRIX_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CSM_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("csr sparse matrix engine check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CSM_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("csr sparse matrix engine check failed");

`endif

@@ sv/csm_pkg.sv @@
// ----------------------------------------------------------------------------
// csm_pkg
// Types and codes of the compressed-sparse-row matrix engine.
// ----------------------------------------------------------------------------
package csm_pkg;

  // item kinds
  localparam logic [2:0] KIND_LOAD_ROW = 3'd0;
  localparam logic [2:0] KIND_LOAD_COL = 3'd1;
  localparam logic [2:0] KIND_LOAD_VEC = 3'd2;
  localparam logic [2:0] KIND_ACC      = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;
  localparam logic [2:0] KIND_MUL      = 3'd5;

  // configuration register indexes
  localparam logic CFG_ROW_COUNT    = 1'b0;
  localparam logic CFG_COLUMN_COUNT = 1'b1;

  // request word
  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         row;
    logic [7:0]         column;
    logic [12:0]        slot;
    logic [12:0]        word;
    logic signed [31:0] number;
  } in_t;

  // result word
  typedef struct packed {
    logic signed [31:0] result_value;
    logic               found;
    logic               out_of_range;
    logic               saturated;
  } out_t;

endpackage

@@ sv/csr_sparse_matrix_engine.sv @@
// ----------------------------------------------------------------------------
// csr_sparse_matrix_engine
// Compressed-sparse-row matrix store with accumulate, read and row-times-vector.
// ----------------------------------------------------------------------------
// Usage:
//   Requests: a word on in_item is taken on a clock edge where start is high
//   and busy is low. Load kinds (row start, column index, vector element) are
//   written in that cycle and leave busy low, so loads go one per cycle.
//   Accumulate, read and multiply-row answer with one word on out_item,
//   marked by a one-cycle out_valid strobe; the receiver cannot stall it.
//   Out-of-range requests answer on the next cycle and keep busy low.
//   Scan: the row bounds are first fetched from the row-start RAM in S_LO
//   and S_HI, then the row is scanned one nonzero per cycle through the
//   column/value RAMs. Read or accumulate stops at the match in the row
//   (the whole row is scanned when absent). For multiply row the column ->
//   vector -> multiply -> add chain is pipelined.
//   Reset: after rst_n the value RAM is swept to zero, one entry per cycle,
//   with busy high. Configuration writes through cfg_* are taken at any time;
//   row_count and column_count reset to 1.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_engine #(
  parameter int MAX_ROWS     = 256,
  parameter int MAX_NONZEROS = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  csm_pkg::in_t  in_item,
  output logic          out_valid,
  output csm_pkg::out_t out_item,
  input  logic          cfg_wr_en,
  input  logic          cfg_index,
  input  logic [8:0]    cfg_data
);

  import csm_pkg::*;

  localparam int RS_DEPTH = MAX_ROWS + 1;
  localparam int RS_AW    = $clog2(RS_DEPTH);
  localparam int NZ_AW    = $clog2(MAX_NONZEROS);
  localparam int BW       = (NZ_AW + 1 > 13) ? NZ_AW + 1 : 13;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_LO    = 3'd2;
  localparam logic [2:0] S_HI    = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;

  localparam logic signed [48:0] SUM_MAX = 49'sd2147483647;
  localparam logic signed [48:0] SUM_MIN = -49'sd2147483648;

  // clamp a wide sum to 32 bits; msb flags saturation
  function automatic logic [32:0] sat32(input logic signed [48:0] v);
    logic [32:0] r;
    if (v > SUM_MAX) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < SUM_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // clamp a row bound to the table size
  function automatic logic [BW-1:0] clamp_bound(input logic [12:0] b);
    logic [BW-1:0] e;
    e = BW'(b);
    if (e > BW'(MAX_NONZEROS)) begin
      e = BW'(MAX_NONZEROS);
    end
    return e;
  endfunction

  // registers
  logic [2:0]         state_r, state_nxt;
  logic [NZ_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [8:0]         row_count_r, column_count_r;
  logic [2:0]         kind_r;
  logic [7:0]         row_r, col_r;
  logic signed [31:0] num_r;
  logic [BW-1:0]      k_r, k_nxt;
  logic [BW-1:0]      hi_r, hi_nxt;
  logic               p1_v_r, p1_v_nxt;
  logic [NZ_AW-1:0]   p1_a_r;
  logic               p2_v_r, p2_v_nxt;
  logic signed [31:0] val_p2_r;
  logic               p3_v_r, p3_v_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic               sat_r, sat_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_r, out_nxt;

  // RAM ports
  logic             rs_we;
  logic [RS_AW-1:0] rs_wa, rs_ra;
  logic [12:0]      rs_rd;
  logic             col_we;
  logic [NZ_AW-1:0] col_wa, nz_ra;
  logic [7:0]       col_rd;
  logic             val_we;
  logic [NZ_AW-1:0] val_wa;
  logic [31:0]      val_wd, val_rd;
  logic             vec_we;
  logic [31:0]      vec_rd;

  // datapath
  logic               accept, item_oor, is_query, issue, hit, finish;
  logic signed [31:0] val_rd_s, vec_rd_s;
  logic [32:0]        acc_sat, mul_sat;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign accept    = start && !busy;
  assign val_rd_s  = signed'(val_rd);
  assign vec_rd_s  = signed'(vec_rd);

  assign is_query = (in_item.kind == KIND_ACC) || (in_item.kind == KIND_READ) ||
                    (in_item.kind == KIND_MUL);
  assign item_oor = ({1'b0, in_item.row} >= row_count_r) ||
                    (32'(in_item.row) >= MAX_ROWS) ||
                    ((in_item.kind != KIND_MUL) && ({1'b0, in_item.column} >= column_count_r));

  // scan control
  assign issue = (k_r < hi_r);
  assign hit   = (state_r == S_SCAN) && p1_v_r && (kind_r != KIND_MUL) && (col_rd == col_r);

  // accumulate add and dot-product add, both clamped
  assign acc_sat = sat32(49'(val_rd_s) + 49'(num_r));
  assign mul_sat = sat32(49'(acc_r) + 49'(signed'(prod_r[63:16])));
  assign prod_nxt = val_p2_r * vec_rd_s;

  // row-start RAM ports
  assign rs_we = accept && (in_item.kind == KIND_LOAD_ROW) && (32'(in_item.slot) <= MAX_ROWS);
  assign rs_wa = RS_AW'(in_item.slot);
  assign rs_ra = (state_r == S_LO) ? RS_AW'({1'b0, row_r} + 9'd1) : RS_AW'(in_item.row);

  // column RAM ports
  assign col_we = accept && (in_item.kind == KIND_LOAD_COL) &&
                  (32'(in_item.slot) < MAX_NONZEROS);
  assign col_wa = NZ_AW'(in_item.slot);
  assign nz_ra  = NZ_AW'(k_r);

  // vector RAM ports
  assign vec_we = accept && (in_item.kind == KIND_LOAD_VEC);

  // value RAM write: clearing sweep or accumulate write-back
  always_comb begin
    val_we = 1'b0;
    val_wa = p1_a_r;
    val_wd = acc_sat[31:0];
    if (state_r == S_CLEAR) begin
      val_we = 1'b1;
      val_wa = clr_cnt_r;
      val_wd = '0;
    end else if (hit && (kind_r == KIND_ACC)) begin
      val_we = 1'b1;
    end
  end

  csm_ram #(.WIDTH(13), .DEPTH(RS_DEPTH)) u_rs_ram (
    .clk(clk), .wr_en(rs_we), .wr_addr(rs_wa), .wr_data(in_item.word),
    .rd_addr(rs_ra), .rd_data(rs_rd)
  );

  csm_ram #(.WIDTH(8), .DEPTH(MAX_NONZEROS)) u_col_ram (
    .clk(clk), .wr_en(col_we), .wr_addr(col_wa), .wr_data(in_item.word[7:0]),
    .rd_addr(nz_ra), .rd_data(col_rd)
  );

  csm_ram #(.WIDTH(32), .DEPTH(MAX_NONZEROS)) u_val_ram (
    .clk(clk), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_wd),
    .rd_addr(nz_ra), .rd_data(val_rd)
  );

  csm_ram #(.WIDTH(32), .DEPTH(256)) u_vec_ram (
    .clk(clk), .wr_en(vec_we), .wr_addr(in_item.column), .wr_data(in_item.number),
    .rd_addr(col_rd), .rd_data(vec_rd)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    k_nxt         = k_r;
    hi_nxt        = hi_r;
    p1_v_nxt      = 1'b0;
    p2_v_nxt      = 1'b0;
    p3_v_nxt      = 1'b0;
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    finish        = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + NZ_AW'(1);
        if (clr_cnt_r == NZ_AW'(MAX_NONZEROS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && is_query) begin
          if (item_oor) begin
            out_valid_nxt        = 1'b1;
            out_nxt.result_value = '0;
            out_nxt.found        = 1'b0;
            out_nxt.out_of_range = 1'b1;
            out_nxt.saturated    = 1'b0;
          end else begin
            state_nxt = S_LO;
            acc_nxt   = '0;
            sat_nxt   = 1'b0;
          end
        end
      end
      S_LO: begin
        k_nxt     = clamp_bound(rs_rd);
        state_nxt = S_HI;
      end
      S_HI: begin
        hi_nxt    = clamp_bound(rs_rd);
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // issue one nonzero per cycle
        p1_v_nxt = issue;
        if (issue) begin
          k_nxt = k_r + BW'(1);
        end
        if (kind_r == KIND_MUL) begin
          p2_v_nxt = p1_v_r;
          p3_v_nxt = p2_v_r;
          if (p3_v_r) begin
            acc_nxt = signed'(mul_sat[31:0]);
            sat_nxt = sat_r | mul_sat[32];
          end
          finish = !issue && !p1_v_r && !p2_v_r && !p3_v_r;
          out_nxt.result_value = acc_r;
          out_nxt.found        = 1'b1;
          out_nxt.out_of_range = 1'b0;
          out_nxt.saturated    = sat_r;
        end else begin
          finish = hit || (!issue && !p1_v_r);
          out_nxt.out_of_range = 1'b0;
          out_nxt.found        = hit;
          out_nxt.result_value = '0;
          out_nxt.saturated    = 1'b0;
          if (hit) begin
            if (kind_r == KIND_ACC) begin
              out_nxt.result_value = signed'(acc_sat[31:0]);
              out_nxt.saturated    = acc_sat[32];
            end else begin
              out_nxt.result_value = val_rd_s;
            end
          end
        end
        if (finish) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          p1_v_nxt      = 1'b0;
        end else begin
          out_nxt = out_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      row_count_r    <= 9'd1;
      column_count_r <= 9'd1;
      p1_v_r         <= 1'b0;
      p2_v_r         <= 1'b0;
      p3_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p2_v_nxt;
      p3_v_r      <= p3_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_ROW_COUNT:    row_count_r    <= cfg_data;
          CFG_COLUMN_COUNT: column_count_r <= cfg_data;
          default:          row_count_r    <= row_count_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_item.kind;
      row_r  <= in_item.row;
      col_r  <= in_item.column;
      num_r  <= in_item.number;
    end
    k_r      <= k_nxt;
    hi_r     <= hi_nxt;
    p1_a_r   <= nz_ra;
    val_p2_r <= val_rd_s;
    prod_r   <= prod_nxt;
    acc_r    <= acc_nxt;
    sat_r    <= sat_nxt;
    out_r    <= out_nxt;
  end

endmodule

@@ sv/csm_ram.sv @@
// ----------------------------------------------------------------------------
// csm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module csm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ sv/csm_checker.sv @@
// ----------------------------------------------------------------------------
// csm_checker
// Port-level checks on the sparse matrix engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "csr_sparse_matrix_engine_defines.svh"

module csm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input csm_pkg::in_t  in_item,
  input logic          out_valid,
  input csm_pkg::out_t out_item
);

  import csm_pkg::*;

  // out-of-range answers carry nothing else
  `CSM_ASSERT_IMP(a_oor_clean, out_valid && out_item.out_of_range, (out_item.result_value == 0) && !out_item.found && !out_item.saturated)

  // a missing entry reads as zero without saturation
  `CSM_ASSERT_IMP(a_absent_zero, out_valid && !out_item.found, (out_item.result_value == 0) && !out_item.saturated)

  // saturation only comes from a completed sum
  `CSM_ASSERT_IMP(a_sat_found, out_valid && out_item.saturated, out_item.found && !out_item.out_of_range)

  // loads never occupy the engine
  `CSM_ASSERT_NXT(a_load_free, start && !busy && (in_item.kind == KIND_LOAD_ROW || in_item.kind == KIND_LOAD_COL || in_item.kind == KIND_LOAD_VEC), !busy && !out_valid)

endmodule

bind csr_sparse_matrix_engine csm_checker u_csm_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
  .out_valid(out_valid), .out_item(out_item)
);

@@ verif/csr_sparse_matrix_engine_tb.sv @@
// ----------------------------------------------------------------------------
// csr_sparse_matrix_engine_tb
// Self-checking bench for the compressed-sparse-row matrix engine. A short
// directed run covers the value extremes, clamping of row bounds, ignored
// loads, wide column words, empty rows and saturating sums. Several
// row/column count settings follow. Each one lays out a fresh row pattern
// and then runs random accumulate, read, multiply-row and load words against
// a predictor in the scoreboard.
// ----------------------------------------------------------------------------
module csr_sparse_matrix_engine_tb;
  import csm_pkg::*;

  localparam int ROWS_MAX      = 256;
  localparam int NNZ_MAX       = 4096;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int STALL_LIMIT   = 20000;
  localparam int RANDOM_WORDS  = 700;

  // kinds the block ignores
  localparam logic [2:0] KIND_SPARE_0 = 3'd6;
  localparam logic [2:0] KIND_SPARE_1 = 3'd7;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the matrix stores and queues the answers due
  // --------------------------------------------------------------------------
  class matrix_scoreboard;
    int row_lim;
    int col_lim;
    logic [12:0]        row_start [0:ROWS_MAX];
    bit                 rs_ok     [0:ROWS_MAX];
    logic [7:0]         col_of    [0:NNZ_MAX-1];
    bit                 col_ok    [0:NNZ_MAX-1];
    logic signed [31:0] value_of  [0:NNZ_MAX-1];
    logic signed [31:0] vec_of    [0:255];
    bit                 vec_ok    [0:255];
    out_t answers_due [$];
    bit   clipped;
    int   failures;
    int   answers_seen;
    int   oor_seen;
    int   absent_seen;
    int   clipped_seen;

    function new();
      row_lim = 1;
      col_lim = 1;
      foreach (rs_ok[i]) rs_ok[i] = 1'b0;
      foreach (col_ok[i]) begin
        col_ok[i]   = 1'b0;
        value_of[i] = '0;
      end
      foreach (vec_ok[i]) vec_ok[i] = 1'b0;
    endfunction

    function void set_register(logic idx, int value);
      if (idx == CFG_ROW_COUNT) row_lim = value;
      else col_lim = value;
    endfunction

    // row bound, clamped to the table depth
    function int bound(int s);
      return (row_start[s] > NNZ_MAX) ? NNZ_MAX : int'(row_start[s]);
    endfunction

    function bit off_limits(in_t w);
      return (w.row >= row_lim) || (w.kind != KIND_MUL && w.column >= col_lim);
    endfunction

    // true when scanning row r touches only written entries
    function bit row_ready(input int r, input bit need_vec, output int lo, output int hi);
      lo = 0;
      hi = 0;
      if (!rs_ok[r] || !rs_ok[r + 1]) return 1'b0;
      lo = bound(r);
      hi = bound(r + 1);
      for (int k = lo; k < hi; k++)
        if (!col_ok[k] || (need_vec && !vec_ok[col_of[k]])) return 1'b0;
      return 1'b1;
    endfunction

    function bit request_safe(in_t w);
      int lo;
      int hi;
      if (w.kind != KIND_ACC && w.kind != KIND_READ && w.kind != KIND_MUL) return 1'b1;
      if (off_limits(w)) return 1'b1;
      return row_ready(w.row, w.kind == KIND_MUL, lo, hi);
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) begin
        clipped = 1'b1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        clipped = 1'b1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    // apply an accepted word and queue the answer it causes
    function void note_request(in_t w);
      out_t   ans;
      int     lo;
      int     hi;
      longint acc;
      longint prod;
      ans = '0;
      clipped = 1'b0;
      case (w.kind)
        KIND_LOAD_ROW: begin
          if (w.slot <= ROWS_MAX) begin
            row_start[w.slot] = w.word;
            rs_ok[w.slot] = 1'b1;
          end
          return;
        end
        KIND_LOAD_COL: begin
          if (w.slot < NNZ_MAX) begin
            col_of[w.slot] = w.word[7:0];
            col_ok[w.slot] = 1'b1;
          end
          return;
        end
        KIND_LOAD_VEC: begin
          vec_of[w.column] = w.number;
          vec_ok[w.column] = 1'b1;
          return;
        end
        KIND_ACC, KIND_READ, KIND_MUL: ;
        default: return;
      endcase
      if (off_limits(w)) begin
        ans.out_of_range = 1'b1;
      end else begin
        lo = bound(w.row);
        hi = bound(int'(w.row) + 1);
        if (w.kind == KIND_MUL) begin
          ans.found = 1'b1;
          acc = 0;
          for (int k = lo; k < hi; k++) begin
            prod = longint'(value_of[k]) * longint'(vec_of[col_of[k]]);
            acc = clamp32(acc + (prod >>> 16));
          end
          ans.result_value = 32'(acc);
        end else begin
          for (int k = lo; k < hi; k++) begin
            if (col_of[k] == w.column) begin
              ans.found = 1'b1;
              if (w.kind == KIND_ACC)
                value_of[k] = 32'(clamp32(longint'(value_of[k]) + longint'(w.number)));
              ans.result_value = value_of[k];
              break;
            end
          end
        end
      end
      ans.saturated = clipped;
      answers_due.push_back(ans);
    endfunction

    function void report(string what, out_t want, out_t got);
      failures++;
      if (failures <= 10)
        $display("%s: expected value %h found %b range %b sat %b, got value %h found %b range %b sat %b",
                 what, want.result_value, want.found, want.out_of_range, want.saturated,
                 got.result_value, got.found, got.out_of_range, got.saturated);
    endfunction

    function void check_answer(out_t got);
      out_t want;
      if (answers_due.size() == 0) begin
        report("answer with none due", '0, got);
        return;
      end
      want = answers_due.pop_front();
      answers_seen++;
      if (want.out_of_range) oor_seen++;
      else if (!want.found) absent_seen++;
      if (want.saturated) clipped_seen++;
      if (got.result_value !== want.result_value || got.found !== want.found ||
          got.out_of_range !== want.out_of_range || got.saturated !== want.saturated)
        report("answer mismatch", want, got);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  in_t        in_item;
  logic       out_valid;
  out_t       out_item;
  logic       cfg_wr_en;
  logic       cfg_index;
  logic [8:0] cfg_data;

  matrix_scoreboard board;
  int stall_cycles   = 0;
  int random_done    = 0;
  int words_sent     = 0;
  int settings_used  = 0;

  csr_sparse_matrix_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result monitor: values read here are the ones present at the edge
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_answer(out_item);
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_valid) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Word builders
  // --------------------------------------------------------------------------
  function automatic in_t make_word(logic [2:0] kind, logic [7:0] row, logic [7:0] column,
                                    logic [12:0] slot, logic [12:0] word,
                                    logic signed [31:0] number);
    in_t w;
    w.kind   = kind;
    w.row    = row;
    w.column = column;
    w.slot   = slot;
    w.word   = word;
    w.number = number;
    return w;
  endfunction

  // Q16.16 value over a wide spread of magnitudes
  function automatic logic signed [31:0] q16_sample();
    logic signed [31:0] v;
    v = $signed(32'($urandom));
    return v >>> $urandom_range(0, 20);
  endfunction

  // column word: mostly in range, sometimes any 13-bit value
  function automatic logic [12:0] pick_column_word(int cols);
    if ($urandom_range(0, 4) == 0) return 13'($urandom);
    return 13'($urandom_range(0, cols - 1));
  endfunction

  function automatic in_t pick_request();
    in_t w;
    int  roll;
    int  lo;
    int  hi;
    int  r;
    w = make_word(3'($urandom), 8'($urandom), 8'($urandom), 13'($urandom), 13'($urandom),
                  q16_sample());
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      // requests, mostly on rows in use and columns in the row pattern
      w.kind = (roll < 30) ? KIND_ACC : (roll < 55) ? KIND_READ : KIND_MUL;
      if ($urandom_range(0, 9) != 0) w.row = 8'($urandom_range(0, board.row_lim - 1));
      r = w.row;
      if (board.row_ready(r, 1'b0, lo, hi) && hi > lo && $urandom_range(0, 9) < 6)
        w.column = board.col_of[$urandom_range(lo, hi - 1)];
      else if ($urandom_range(0, 9) < 8)
        w.column = 8'($urandom_range(0, board.col_lim - 1));
    end else if (roll < 83) begin
      w.kind = KIND_LOAD_VEC;
    end else if (roll < 89) begin
      // rewrite a column inside a row, or a slot past the table
      w.kind = KIND_LOAD_COL;
      w.word = pick_column_word(board.col_lim);
      r = $urandom_range(0, board.row_lim - 1);
      if ($urandom_range(0, 1) == 0 && board.row_ready(r, 1'b0, lo, hi) && hi > lo)
        w.slot = 13'($urandom_range(lo, hi - 1));
      else
        w.slot = 13'($urandom_range(NNZ_MAX, 8191));
    end else if (roll < 94) begin
      // nudge a row start, or a slot past the table
      w.kind = KIND_LOAD_ROW;
      r = $urandom_range(0, board.row_lim);
      if ($urandom_range(0, 2) == 0 && board.rs_ok[r]) begin
        w.slot = 13'(r);
        w.word = 13'(int'(board.row_start[r]) + int'($urandom_range(0, 4)) - 2);
      end else begin
        w.slot = 13'($urandom_range(ROWS_MAX + 1, 8191));
      end
    end else if (roll < 97) begin
      w.kind = ($urandom_range(0, 1) == 0) ? KIND_SPARE_0 : KIND_SPARE_1;
    end
    // anything left is noise; never scan entries that were not written
    if (!board.request_safe(w)) w.kind = KIND_LOAD_VEC;
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_word(input in_t w);
    int pct;
    pct = (random_done < RANDOM_WORDS / 3) ? 14 : (random_done < 2 * RANDOM_WORDS / 3) ? 49 : 0;
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(w);
    words_sent++;
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(input logic idx, input int value);
    start <= 1'b0;
    while (board.answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 9'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_register(idx, value);
  endtask

  // row starts 0..rows, the column of every position, and the vector
  // entries those columns use
  task automatic build_pattern(input int rows, input int cols, input int base,
                               input int max_len);
    int         pos;
    int         len;
    logic [7:0] c;
    in_t        w;
    pos = base;
    for (int s = 0; s <= rows; s++) begin
      send_word(make_word(KIND_LOAD_ROW, 8'($urandom), 8'($urandom), 13'(s),
                          13'((pos > 8191) ? 8191 : pos), q16_sample()));
      if (s < rows) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 24) : $urandom_range(0, max_len);
        for (int k = pos; k < pos + len && k < NNZ_MAX; k++) begin
          w = make_word(KIND_LOAD_COL, 8'($urandom), 8'($urandom), 13'(k),
                        pick_column_word(cols), q16_sample());
          send_word(w);
          c = w.word[7:0];
          if (!board.vec_ok[c])
            send_word(make_word(KIND_LOAD_VEC, 8'($urandom), c, 13'($urandom),
                                13'($urandom), q16_sample()));
        end
        pos += len;
      end
    end
  endtask

  task automatic run_setting(input int rows, input int cols, input int base,
                             input int max_len, input int count);
    write_reg(CFG_ROW_COUNT, rows);
    write_reg(CFG_COLUMN_COUNT, cols);
    settings_used++;
    build_pattern(rows, cols, base, max_len);
    repeat (count) begin
      send_word(pick_request());
      random_done++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int rows;
    int cols;
    board = new();
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // out of range under the reset counts (one row, one column)
    send_word(make_word(KIND_ACC,  8'd1, 8'd0,   13'd0, 13'd0, 32'sd5));
    send_word(make_word(KIND_READ, 8'd0, 8'd255, 13'd0, 13'd0, 32'sd0));

    write_reg(CFG_ROW_COUNT, 256);
    write_reg(CFG_COLUMN_COUNT, 256);
    // row 0 = positions 0..1, row 1 empty, row 255 clamped to 4094..4095
    send_word(make_word(KIND_LOAD_ROW, 8'd0, 8'd0, 13'd0,    13'd0,    32'sd0));
    send_word(make_word(KIND_LOAD_ROW, 8'd0, 8'd0, 13'd1,    13'd2,    32'sd0));
    send_word(make_word(KIND_LOAD_ROW, 8'd0, 8'd0, 13'd2,    13'd2,    32'sd0));
    send_word(make_word(KIND_LOAD_ROW, 8'd0, 8'd0, 13'd255,  13'd4094, 32'sd0));
    send_word(make_word(KIND_LOAD_ROW, 8'd0, 8'd0, 13'd256,  13'd8191, 32'sd0));
    send_word(make_word(KIND_LOAD_ROW, 8'd0, 8'd0, 13'd8191, 13'd1,    32'sd0));
    // columns, a wide column word, and a slot past the table
    send_word(make_word(KIND_LOAD_COL, 8'd0, 8'd0, 13'd0,    13'd5,     32'sd0));
    send_word(make_word(KIND_LOAD_COL, 8'd0, 8'd0, 13'd1,    13'h1FF,   32'sd0));
    send_word(make_word(KIND_LOAD_COL, 8'd0, 8'd0, 13'd4094, 13'd0,     32'sd0));
    send_word(make_word(KIND_LOAD_COL, 8'd0, 8'd0, 13'd4095, 13'd255,   32'sd0));
    send_word(make_word(KIND_LOAD_COL, 8'd0, 8'd0, 13'd8191, 13'd0,     32'sd0));
    // vector extremes
    send_word(make_word(KIND_LOAD_VEC, 8'd0, 8'd5,   13'd0, 13'd0, 32'h7FFF_FFFF));
    send_word(make_word(KIND_LOAD_VEC, 8'd0, 8'd255, 13'd0, 13'd0, 32'h8000_0000));
    send_word(make_word(KIND_LOAD_VEC, 8'd0, 8'd0,   13'd0, 13'd0, 32'h0001_0000));
    // accumulate to both rails, then a column not in the row
    send_word(make_word(KIND_ACC, 8'd0, 8'd5,   13'd0, 13'd0, 32'h7FFF_FFFF));
    send_word(make_word(KIND_ACC, 8'd0, 8'd5,   13'd0, 13'd0, 32'sd1));
    send_word(make_word(KIND_ACC, 8'd0, 8'd255, 13'd0, 13'd0, 32'h8000_0000));
    send_word(make_word(KIND_ACC, 8'd0, 8'd7,   13'd0, 13'd0, 32'sd5));
    send_word(make_word(KIND_READ, 8'd0, 8'd5,  13'd0, 13'd0, 32'sd0));
    // dot products: saturating row, empty row, clamped last row
    send_word(make_word(KIND_MUL, 8'd0,   8'd0, 13'd0, 13'd0, 32'sd0));
    send_word(make_word(KIND_MUL, 8'd1,   8'd0, 13'd0, 13'd0, 32'sd0));
    send_word(make_word(KIND_ACC, 8'd255, 8'd255, 13'd0, 13'd0, 32'hFFFF_8000));
    send_word(make_word(KIND_MUL, 8'd255, 8'd0, 13'd0, 13'd0, 32'sd0));
    send_word(make_word(KIND_SPARE_0, 8'd0, 8'd0, 13'd0, 13'd0, 32'sd0));

    // random phases over several count settings
    run_setting(256, 256, 0, 2, 150);
    run_setting(5, 3, 100, 8, 110);
    run_setting(1, 1, 200, 12, 80);
    run_setting(12, 256, 4080, 4, 100);
    rows = $urandom_range(2, 64);
    cols = $urandom_range(2, 255);
    run_setting(rows, cols, $urandom_range(0, 3000), 6, 130);
    run_setting(256, 1, 0, 3, 130);

    // drain
    start <= 1'b0;
    while (board.answers_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d words over %0d count settings; %0d answers checked",
             words_sent, settings_used, board.answers_seen);
    $display("  %0d out of range, %0d absent entries, %0d saturated sums",
             board.oor_seen, board.absent_seen, board.clipped_seen);
    if (board.failures == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/csm_pkg.sv
sv/csm_ram.sv
sv/csr_sparse_matrix_engine.sv
sv/csm_checker.sv
verif/csr_sparse_matrix_engine_tb.sv
